// ===== hdl/b32e_pkg.sv =====
// Shared types and constants for the base32 stream encoder.
package b32e_pkg;

    localparam int SYM_BITS    = 5;
    localparam int CHAR_BITS   = 8;
    localparam int NUM_CHARS   = 32;
    localparam int NUM_WORDS   = 8;
    localparam int WORD_BITS   = 32;
    localparam int MAX_SYMS    = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Reset alphabet "ABCDEFGHIJKLMNOPQRSTUVWXYZ123456", character 0 in low byte
    localparam logic [NUM_WORDS-1:0][WORD_BITS-1:0] ALPHA_RESET = {
        32'd909456435,  32'd842095193,  32'd1482118741, 32'd1414746705,
        32'd1347374669, 32'd1280002633, 32'd1212630597, 32'd1145258561
    };

    // One classified byte: up to three 5-bit alphabet indices
    typedef struct packed {
        logic [MAX_SYMS-1:0][SYM_BITS-1:0] sym;   // symbol 0 emitted first
        logic [1:0]                        num;   // symbols in use, 1 to 3
        logic                              last;  // final symbol is last of message
    } q_entry_t;

endpackage

// ===== hdl/base32_stream_encoder.sv =====
// Base32 stream encoder top level: alphabet registers, front end, queue, back end.
//
// Input channel s_*: one raw byte per item in s_tdata, s_tlast marks the last
// byte of a message. Bits are consumed most significant first, five at a time.
// Output channel m_*: one alphabet character per item in m_tdata; m_tlast marks
// the final character of a message (leftover bits are zero padded on the right).
// Configuration channel cfg_*: writes alphabet word cfg_index (0 to 7), four
// characters per word, lowest index in the low byte; other indexes are ignored.
// cfg_ready is always high; write only while the encoder is idle.
// Path: an accepted byte is written to a queue entry, loaded into the current-item
// register, then mapped into the output register on m_*. The back end emits one
// character per cycle while m_tready allows; a byte makes one to three characters
// (1.6 on average), so sustained intake is limited by that output rate. A four-entry
// queue between front and back end lets input keep flowing during bursts.
// Reset: pending bits cleared, queue and output emptied, alphabet restored to
// "ABCDEFGHIJKLMNOPQRSTUVWXYZ123456".
// Stall: when m_tready is low the output holds; once the queue fills, s_tready drops.
module base32_stream_encoder
    import b32e_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_BITS-1:0] s_tdata,    // [7:0] data_byte
    input  logic                 s_tlast,    // end_of_message
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_BITS-1:0] m_tdata,    // [7:0] symbol_char
    output logic                 m_tlast,    // final_symbol
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    logic [NUM_WORDS-1:0][WORD_BITS-1:0]  alpha_reg, alpha_next;
    logic [NUM_CHARS-1:0][CHAR_BITS-1:0]  alphabet;
    logic                                 q_full, q_push, q_pop, q_valid;
    q_entry_t                             push_entry, head_entry;

    assign cfg_ready = 1'b1;

    // Alphabet register file
    always_comb begin
        alpha_next = alpha_reg;
        if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_WORDS))) begin
            alpha_next[cfg_index[2:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
        end else begin
            alpha_reg <= alpha_next;
        end
    end

    assign alphabet = alpha_reg;

    b32e_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    b32e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    b32e_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .alphabet  (alphabet),
        .q_valid   (q_valid),
        .q_entry   (head_entry),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== hdl/b32e_front.sv =====
// Front end: accepts bytes, cuts the bit stream into 5-bit groups per item.
module b32e_front
    import b32e_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CHAR_BITS-1:0] in_data,
    input  logic                 in_last,
    input  logic                 q_full,
    output logic                 q_push,
    output q_entry_t             q_entry
);

    logic [3:0]          pend_bits_reg, pend_bits_next;
    logic [2:0]          pend_cnt_reg,  pend_cnt_next;
    logic [11:0]         acc;
    logic [SYM_BITS-1:0] sym0, sym1, pad_sym;
    logic                two;
    logic                has_rem;
    logic [3:0]          rem_bits;
    logic [2:0]          rem_cnt;
    logic                accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign acc      = {pend_bits_reg, in_data};

    // Group split by how many bits were left over from earlier bytes
    always_comb begin
        sym1     = '0;
        two      = 1'b0;
        rem_bits = '0;
        rem_cnt  = '0;
        pad_sym  = '0;
        case (pend_cnt_reg)
            3'd0: begin
                sym0     = acc[7:3];
                rem_cnt  = 3'd3;
                rem_bits = {1'b0, acc[2:0]};
                pad_sym  = {acc[2:0], 2'b00};
            end
            3'd1: begin
                sym0     = acc[8:4];
                rem_cnt  = 3'd4;
                rem_bits = acc[3:0];
                pad_sym  = {acc[3:0], 1'b0};
            end
            3'd2: begin
                sym0 = acc[9:5];
                sym1 = acc[4:0];
                two  = 1'b1;
            end
            3'd3: begin
                sym0     = acc[10:6];
                sym1     = acc[5:1];
                two      = 1'b1;
                rem_cnt  = 3'd1;
                rem_bits = {3'b000, acc[0]};
                pad_sym  = {acc[0], 4'b0000};
            end
            default: begin
                sym0     = acc[11:7];
                sym1     = acc[6:2];
                two      = 1'b1;
                rem_cnt  = 3'd2;
                rem_bits = {2'b00, acc[1:0]};
                pad_sym  = {acc[1:0], 3'b000};
            end
        endcase
    end

    assign has_rem = in_last && (rem_cnt != 3'd0);

    // Pack the symbols of this item, padded group after the full ones
    always_comb begin
        q_entry.sym[0] = sym0;
        q_entry.sym[1] = two ? sym1 : pad_sym;
        q_entry.sym[2] = pad_sym;
        q_entry.num    = 2'd1 + {1'b0, two} + {1'b0, has_rem};
        q_entry.last   = in_last;
    end

    // Leftover bits, cleared at a message boundary
    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (accept) begin
            if (in_last) begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end else begin
                pend_bits_next = rem_bits;
                pend_cnt_next  = rem_cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

// ===== hdl/b32e_queue.sv =====
// Short FIFO of classified items between front and back end.
module b32e_queue
    import b32e_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_entry
);

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg,    cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/b32e_back.sv =====
// Back end: walks each item's symbols, maps them through the alphabet, drives output.
module b32e_back
    import b32e_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [NUM_CHARS-1:0][CHAR_BITS-1:0] alphabet,
    input  logic                                q_valid,
    input  q_entry_t                            q_entry,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [CHAR_BITS-1:0]                out_data,
    output logic                                out_last
);

    q_entry_t             cur_reg,       cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [1:0]           idx_reg,       idx_next;
    logic                 oval_reg,      oval_next;
    logic [CHAR_BITS-1:0] odata_reg,     odata_next;
    logic                 olast_reg,     olast_next;
    logic                 out_free, emit, last_sym, cur_done;

    assign out_free = !oval_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign last_sym = (idx_reg == 2'(cur_reg.num - 2'd1));
    assign cur_done = emit && last_sym;
    assign q_pop    = q_valid && (!cur_valid_reg || cur_done);

    // Current item: load from queue when empty or finishing
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop) begin
            cur_next       = q_entry;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (cur_done) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Output register with alphabet lookup
    always_comb begin
        oval_next  = oval_reg;
        odata_next = odata_reg;
        olast_next = olast_reg;
        if (emit) begin
            oval_next  = 1'b1;
            odata_next = alphabet[cur_reg.sym[idx_reg]];
            olast_next = cur_reg.last && last_sym;
        end else if (out_ready) begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            oval_reg      <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            oval_reg      <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

// ===== tb/sv/tb_base32_stream_encoder.sv =====
// Self-checking testbench for base32_stream_encoder: directed and random streams against a bit-level predictor.
module tb_base32_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b32e_pkg::*;

    localparam int IDLE_PCT    = 14;    // percent of cycles a side idles
    localparam int HOLD_CYCLES = 60;    // long receiver hold-off
    localparam int STUCK_LIMIT = 1000;  // cycles with no handshake at all
    localparam int CHUNK_ITEMS = 48;    // minimum random bytes per alphabet setting

    // Standard alphabet, character 0 in the top byte of the literal
    localparam logic [NUM_CHARS*CHAR_BITS-1:0] STD_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ123456";

    // Configuration indexes past the alphabet words, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST_END = CFG_IDX_W'(NUM_WORDS);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP      = '1;

    typedef enum int {ALPHA_RANDOM, ALPHA_ZERO, ALPHA_ONES, ALPHA_STANDARD} alpha_style_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] data;
        logic                 eom;
    } raw_item_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 fin;
    } sym_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CHAR_BITS-1:0] s_tdata;    // [7:0] data_byte
    logic                 s_tlast;    // end_of_message
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CHAR_BITS-1:0] m_tdata;    // [7:0] symbol_char
    logic                 m_tlast;    // final_symbol
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_BITS-1:0] cfg_data;

    base32_stream_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Byte feed and symbol predictions
    raw_item_t            byte_feed [$];
    sym_t                 sym_expect [$];
    raw_item_t            feed_item;
    sym_t                 want;

    // Predictor state
    logic [CHAR_BITS-1:0] alpha_chars [NUM_CHARS];
    logic [3:0]           pend_bits;
    int                   pend_cnt;

    logic                 s_took;
    logic                 quiet;
    logic                 rx_hold;
    logic                 stall_go;
    int                   sent_cnt;
    int                   taken_cnt;
    int                   sym_cnt;
    int                   msg_cnt;
    int                   cfg_cnt;
    int                   err_cnt;
    int                   stuck_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    // Shift one byte behind the pending bits and queue the symbols it yields
    function automatic void encode_byte(input logic [CHAR_BITS-1:0] b, input logic eom);
        logic [11:0] acc;
        int          total;
        sym_t        s;
        acc   = {pend_bits, b};
        total = pend_cnt + 8;
        while (total >= SYM_BITS) begin
            total -= SYM_BITS;
            s.ch  = alpha_chars[5'(acc >> total)];
            s.fin = 1'b0;
            sym_expect.push_back(s);
        end
        acc = acc & ((12'd1 << total) - 12'd1);
        if (eom) begin
            // leftover bits padded with zeros on the right
            if (total > 0) begin
                s.ch  = alpha_chars[5'(acc << (SYM_BITS - total))];
                s.fin = 1'b0;
                sym_expect.push_back(s);
            end
            sym_expect[sym_expect.size() - 1].fin = 1'b1;
            pend_bits = '0;
            pend_cnt  = 0;
        end else begin
            pend_bits = 4'(acc);
            pend_cnt  = total;
        end
    endfunction

    // Byte driver: holds an item until taken, idles at random
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (byte_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                feed_item = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= feed_item.data;
                s_tlast  <= feed_item.eom;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Symbol receiver backpressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // One long hold-off on the receiver side so the input side backs up
    initial begin
        rx_hold = 1'b0;
        wait (stall_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Monitor: tracks config, predicts on each byte, checks each symbol
    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        if (!aresetn) begin
            pend_bits = '0;
            pend_cnt  = 0;
            for (int i = 0; i < NUM_CHARS; i++)
                alpha_chars[i] = STD_ALPHABET[(NUM_CHARS - 1 - i) * CHAR_BITS +: CHAR_BITS];
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_cnt++;
                if (int'(cfg_index) < NUM_WORDS)
                    for (int k = 0; k < 4; k++)
                        alpha_chars[int'(cfg_index) * 4 + k] = cfg_data[k * CHAR_BITS +: CHAR_BITS];
            end
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                taken_cnt++;
            end
            if (m_tvalid && m_tready) begin
                sym_cnt++;
                if (sym_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected symbol %02h last=%0b",
                                              m_tdata, m_tlast));
                end else begin
                    want = sym_expect.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("symbol_char %02h, predicted %02h",
                                                  m_tdata, want.ch));
                    if (m_tlast !== want.fin)
                        report_mismatch($sformatf("final_symbol %0b, predicted %0b",
                                                  m_tlast, want.fin));
                end
            end
        end
    end

    // Watchdog on total silence
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d symbols outstanding",
                     STUCK_LIMIT, sym_expect.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_byte(input logic [CHAR_BITS-1:0] b, input logic eom);
        raw_item_t it;
        it.data = b;
        it.eom  = eom;
        byte_feed.push_back(it);
        sent_cnt++;
        if (eom)
            msg_cnt++;
    endtask

    // Sender pause: every byte taken and every symbol back
    task automatic wait_drained();
        while (taken_cnt != sent_cnt || sym_expect.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_alphabet(input alpha_style_t style);
        logic [WORD_BITS-1:0] w;
        for (int k = 0; k < NUM_WORDS; k++) begin
            case (style)
                ALPHA_ZERO: w = '0;
                ALPHA_ONES: w = '1;
                ALPHA_STANDARD: begin
                    for (int j = 0; j < 4; j++)
                        w[j * CHAR_BITS +: CHAR_BITS] =
                            STD_ALPHABET[(NUM_CHARS - 1 - (4 * k + j)) * CHAR_BITS +: CHAR_BITS];
                end
                default: w = $urandom();
            endcase
            write_cfg(CFG_IDX_W'(k), w);
        end
    endtask

    // Random messages, mostly short, a few long
    task automatic run_chunk(input int target, input bit with_stall);
        int pushed;
        int len;
        pushed = 0;
        while (pushed < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                push_byte(CHAR_BITS'($urandom_range(0, 255)), i == len - 1);
            pushed += len;
        end
        if (with_stall) begin
            repeat (12) @(negedge aclk);
            stall_go = 1'b1;
        end
        wait_drained();
    endtask

    // Stimulus
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        stall_go  = 1'b0;
        sent_cnt  = 0;
        taken_cnt = 0;
        sym_cnt   = 0;
        msg_cnt   = 0;
        cfg_cnt   = 0;
        err_cnt   = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed messages on the reset alphabet: single bytes with two pad bits,
        // two to four bytes (the two-byte one ending with three symbols), and the exact fit of five
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b1);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(8'h9A, 1'b1);
        wait_drained();

        // Random alphabet, with the long receiver hold-off
        load_alphabet(ALPHA_RANDOM);
        run_chunk(CHUNK_ITEMS, 1'b1);

        // All-zero alphabet
        load_alphabet(ALPHA_ZERO);
        run_chunk(CHUNK_ITEMS, 1'b0);

        // All-ones alphabet, no idling on either side
        load_alphabet(ALPHA_ONES);
        quiet = 1'b1;
        run_chunk(CHUNK_ITEMS, 1'b0);
        quiet = 1'b0;

        // Random alphabet, writes past the last word must be ignored
        load_alphabet(ALPHA_RANDOM);
        write_cfg(CFG_IDX_PAST_END, $urandom());
        write_cfg(CFG_IDX_TOP, $urandom());
        run_chunk(CHUNK_ITEMS, 1'b0);

        // Standard alphabet written back explicitly
        load_alphabet(ALPHA_STANDARD);
        write_cfg(CFG_IDX_TOP, '0);
        run_chunk(CHUNK_ITEMS, 1'b0);

        repeat (10) @(negedge aclk);
        if (sym_expect.size() != 0)
            report_mismatch($sformatf("%0d symbols never arrived", sym_expect.size()));
        $display("run: %0d bytes in %0d messages, %0d symbols checked", taken_cnt, msg_cnt,
                 sym_cnt);
        $display("run: %0d alphabet writes over five settings, %0d mismatches", cfg_cnt,
                 err_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
